// File: hdl/spseq_pkg.sv
`default_nettype none

package spseq_pkg;

  localparam int CMD_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 10;
  localparam int INTERVAL_BITS = 10;
  localparam int STEP_FIELD_BITS = 16;

  localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_WALK  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_OFF   = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXTENSION = 2'd2;

  localparam logic [INTERVAL_BITS-1:0] EXTENSION_RESET = 10'd10;

  typedef struct packed {
    logic coil_in1;
    logic coil_in2;
    logic motor_enable;
    logic busy_res;
    logic walk_done;
  } res_t;

  // coil pattern 2,3,1,0
  function automatic logic [1:0] phase_pattern(input logic [1:0] idx);
    logic [1:0] pat;
    case (idx)
      2'd0:    pat = 2'b10;
      2'd1:    pat = 2'b11;
      2'd2:    pat = 2'b01;
      default: pat = 2'b00;
    endcase
    return pat;
  endfunction

  // step delay in ms: 5,5,10,15
  function automatic logic [INTERVAL_BITS-1:0] speed_delay(input logic [1:0] idx);
    logic [INTERVAL_BITS-1:0] d;
    case (idx)
      2'd0:    d = 10'd5;
      2'd1:    d = 10'd5;
      2'd2:    d = 10'd10;
      default: d = 10'd15;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hdl/stepper_phase_sequencer_core.sv
`default_nettype none

// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------
// input     | in_valid / in_stall          | command, step_count
// result    | res_valid / res_stall        | coil_in1, coil_in2, motor_enable,
//           |                              | busy_res, walk_done
// config    | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One item per clock while in_stall is low; each transfer's result is registered in the output buffer.
// State update is a single pass through the core next-state logic.
// Two-entry output buffer: in_stall rises only once both entries are held.
// cfg_ready is always high. Synchronous reset clears the walk state and buffer flags and loads the config defaults.

module stepper_phase_sequencer_core
  import spseq_pkg::*;
#(
  parameter int STEP_COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [CMD_BITS-1:0]        command,
  input  wire logic [STEP_FIELD_BITS-1:0] step_count,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output logic                            coil_in1,
  output logic                            coil_in2,
  output logic                            motor_enable,
  output logic                            busy_res,
  output logic                            walk_done,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]   cfg_data
);

  logic accept;
  logic full;
  res_t result;
  res_t res_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  spseq_core #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .step_count(step_count),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  spseq_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(result),
    .full     (full),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  assign coil_in1     = res_data.coil_in1;
  assign coil_in2     = res_data.coil_in2;
  assign motor_enable = res_data.motor_enable;
  assign busy_res     = res_data.busy_res;
  assign walk_done    = res_data.walk_done;

endmodule

`default_nettype wire

// File: hdl/spseq_core.sv
`default_nettype none

module spseq_core
  import spseq_pkg::*;
#(
  parameter int STEP_COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [CMD_BITS-1:0]        command,
  input  wire logic [STEP_FIELD_BITS-1:0] step_count,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]   cfg_data,
  output res_t                            result
);

  logic                       direction_forward;
  logic [1:0]                 speed_index;
  logic [INTERVAL_BITS-1:0]   extension_ms;

  logic [1:0]                 phase_index, phase_index_next;
  logic                       phase_started, phase_started_next;
  logic [STEP_COUNT_BITS-1:0] steps_left, steps_left_next;
  logic [INTERVAL_BITS-1:0]   interval_left, interval_left_next;
  logic                       first_interval, first_interval_next;
  logic                       running, running_next;
  logic                       enable_level, enable_level_next;
  logic                       done;
  logic [1:0]                 pat_next;

  logic [STEP_COUNT_BITS-1:0] cnt;
  logic [STEP_COUNT_BITS-1:0] steps_dec;
  logic [STEP_COUNT_BITS-1:0] one_step;

  generate
    if (STEP_COUNT_BITS > STEP_FIELD_BITS) begin : g_wide
      assign cnt = {{(STEP_COUNT_BITS-STEP_FIELD_BITS){1'b0}}, step_count};
    end else if (STEP_COUNT_BITS == STEP_FIELD_BITS) begin : g_same
      assign cnt = step_count;
    end else begin : g_narrow
      assign cnt = step_count[STEP_COUNT_BITS-1:0];
    end
  endgenerate

  assign steps_dec = steps_left - {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1};
  assign one_step  = {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1};
  assign pat_next  = phase_pattern(phase_index_next);

  always_comb begin
    phase_index_next    = phase_index;
    phase_started_next  = phase_started;
    steps_left_next     = steps_left;
    interval_left_next  = interval_left;
    first_interval_next = first_interval;
    running_next        = running;
    enable_level_next   = enable_level;
    done                = 1'b0;
    unique case (command)
      CMD_TICK: begin
        if (running) begin
          if (interval_left <= 10'd1) begin
            if (steps_left == '0) begin
              enable_level_next  = 1'b0;
              running_next       = 1'b0;
              interval_left_next = '0;
              done               = 1'b1;
            end else begin
              // first step ever lands on phase 0
              phase_started_next = 1'b1;
              if (!phase_started) begin
                phase_index_next = 2'd0;
              end else if (direction_forward) begin
                phase_index_next = phase_index + 2'd1;
              end else begin
                phase_index_next = phase_index - 2'd1;
              end
              steps_left_next     = steps_dec;
              first_interval_next = 1'b0;
              if (first_interval || steps_dec == '0) begin
                interval_left_next = extension_ms;
              end else begin
                interval_left_next = speed_delay(speed_index);
              end
            end
          end else begin
            interval_left_next = interval_left - 10'd1;
          end
        end
      end
      CMD_WALK: begin
        steps_left_next     = cnt;
        first_interval_next = (cnt != one_step);
        if (cnt != '0) begin
          enable_level_next  = 1'b1;
          running_next       = 1'b1;
          interval_left_next = speed_delay(speed_index);
        end
      end
      CMD_CLEAR: begin
        steps_left_next = one_step;
      end
      CMD_OFF: begin
        enable_level_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.coil_in1     = phase_started_next & pat_next[1];
    result.coil_in2     = phase_started_next & pat_next[0];
    result.motor_enable = enable_level_next;
    result.busy_res     = running_next;
    result.walk_done    = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index    <= '0;
      phase_started  <= 1'b0;
      steps_left     <= '0;
      interval_left  <= '0;
      first_interval <= 1'b0;
      running        <= 1'b0;
      enable_level   <= 1'b0;
    end else if (accept) begin
      phase_index    <= phase_index_next;
      phase_started  <= phase_started_next;
      steps_left     <= steps_left_next;
      interval_left  <= interval_left_next;
      first_interval <= first_interval_next;
      running        <= running_next;
      enable_level   <= enable_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_forward <= 1'b0;
      speed_index       <= 2'd0;
      extension_ms      <= EXTENSION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION: direction_forward <= cfg_data[0];
        REG_SPEED:     speed_index       <= cfg_data[1:0];
        REG_EXTENSION: extension_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a finishing walk leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> !running)
    else $error("walk_done without walk ending");

  // phase only moves on a transfer
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase_index) && $stable(phase_started))
    else $error("phase moved without a transfer");

  assert property (@(posedge clk) disable iff (rst)
    done |-> running)
    else $error("walk finished while idle");

endmodule

`default_nettype wire

// File: hdl/spseq_out.sv
`default_nettype none

module spseq_out
  import spseq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res_data
);

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign pop       = main_valid && !res_stall;
  assign full      = skid_valid;
  assign res_valid = main_valid;
  assign res_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  // skid only fills behind a held result
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds data with empty output register");

  assert property (@(posedge clk) disable iff (rst)
    (main_valid && res_stall) |=> main_valid && $stable(main_data))
    else $error("held result lost or changed");

  assert property (@(posedge clk) disable iff (rst)
    (push && !main_valid) |=> main_valid && (main_data == $past(push_data)))
    else $error("transfer into empty buffer not presented");

endmodule

`default_nettype wire

// File: verif/tb_stepper_phase_sequencer_core.sv
module tb_stepper_phase_sequencer_core
  import spseq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CMD_BITS-1:0]        cmd;
    logic [STEP_FIELD_BITS-1:0] cnt;
  } motor_cmd_t;

  // coil patterns 2,3,1,0 packed low entry first; step delays 5,5,10,15 ms
  localparam logic [7:0]  COIL_SEQ = {2'b00, 2'b01, 2'b11, 2'b10};
  localparam logic [39:0] DELAY_MS = {10'd15, 10'd10, 10'd5, 10'd5};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CMD_BITS-1:0]        command = CMD_TICK;
  logic [STEP_FIELD_BITS-1:0] step_count = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic                       coil_in1;
  logic                       coil_in2;
  logic                       motor_enable;
  logic                       busy_res;
  logic                       walk_done;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = REG_DIRECTION;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  stepper_phase_sequencer_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .step_count   (step_count),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .coil_in1     (coil_in1),
    .coil_in2     (coil_in2),
    .motor_enable (motor_enable),
    .busy_res     (busy_res),
    .walk_done    (walk_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic                       cfg_forward;
  logic [1:0]                 cfg_speed;
  logic [INTERVAL_BITS-1:0]   cfg_ext_ms;
  logic [1:0]                 motor_phase;
  logic                       has_stepped;
  logic [STEP_FIELD_BITS-1:0] steps_remaining;
  logic [INTERVAL_BITS-1:0]   ms_remaining;
  logic                       ext_pending;
  logic                       walking;
  logic                       enable_q;

  motor_cmd_t pending_cmds[$];
  res_t       expected_coils[$];
  motor_cmd_t next_cmd;
  res_t       want;
  res_t       got;
  int         cmds_queued = 0;
  int         cmds_accepted = 0;
  int         results_checked = 0;
  int         mismatches = 0;
  logic       in_taken = 1'b0;
  logic       back_to_back = 1'b0;
  int         gap_left = 0;
  int         burst_left = 1;
  int         holds_wanted = 0;
  int         holds_given = 0;
  int         hold_left = 0;
  int         stall_span = 0;
  int         stall_mode = 0;

  function automatic res_t sequence_motor(input logic [CMD_BITS-1:0] cmd,
                                          input logic [STEP_FIELD_BITS-1:0] cnt);
    res_t                     r;
    logic [1:0]               coil;
    logic [INTERVAL_BITS-1:0] nxt;
    r.walk_done = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (walking) begin
          if (ms_remaining <= 1) begin
            if (steps_remaining == 0) begin
              enable_q = 1'b0;
              walking = 1'b0;
              ms_remaining = '0;
              r.walk_done = 1'b1;
            end else begin
              // very first step always lands on phase 0
              if (!has_stepped) begin
                motor_phase = 2'd0;
                has_stepped = 1'b1;
              end else if (cfg_forward) begin
                motor_phase = motor_phase + 2'd1;
              end else begin
                motor_phase = motor_phase - 2'd1;
              end
              steps_remaining = steps_remaining - 1'b1;
              if (ext_pending) begin
                nxt = cfg_ext_ms;
                ext_pending = 1'b0;
              end else begin
                nxt = DELAY_MS[10*cfg_speed +: 10];
              end
              if (steps_remaining == 0) nxt = cfg_ext_ms;
              ms_remaining = nxt;
            end
          end else begin
            ms_remaining = ms_remaining - 1'b1;
          end
        end
      end
      CMD_WALK: begin
        steps_remaining = cnt;
        ext_pending = (cnt != 1);
        if (cnt != 0) begin
          enable_q = 1'b1;
          walking = 1'b1;
          ms_remaining = DELAY_MS[10*cfg_speed +: 10];
        end
      end
      CMD_CLEAR: steps_remaining = STEP_FIELD_BITS'(1);
      CMD_OFF:   enable_q = 1'b0;
    endcase
    coil = COIL_SEQ[2*motor_phase +: 2];
    r.coil_in1 = has_stepped & coil[1];
    r.coil_in2 = has_stepped & coil[0];
    r.motor_enable = enable_q;
    r.busy_res = walking;
    return r;
  endfunction

  // ticks from a walk command until its done pulse, with no interference
  function automatic int walk_ticks(input int n, input int dly, input int ext);
    int e1;
    e1 = (ext < 1) ? 1 : ext;
    if (n == 1) return dly + e1;
    return dly + 2*e1 + (n-2)*dly;
  endfunction

  // monitor: config and input transfers feed the predictor, results are checked
  always @(posedge clk) begin
    if (rst) begin
      cfg_forward = 1'b0;
      cfg_speed = 2'd0;
      cfg_ext_ms = EXTENSION_RESET;
      motor_phase = 2'd0;
      has_stepped = 1'b0;
      steps_remaining = '0;
      ms_remaining = '0;
      ext_pending = 1'b0;
      walking = 1'b0;
      enable_q = 1'b0;
      in_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIRECTION: cfg_forward = cfg_data[0];
          REG_SPEED:     cfg_speed = cfg_data[1:0];
          REG_EXTENSION: cfg_ext_ms = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        got = {coil_in1, coil_in2, motor_enable, busy_res, walk_done};
        if (expected_coils.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result in1=%b in2=%b en=%b busy=%b done=%b", $time,
                     got.coil_in1, got.coil_in2, got.motor_enable, got.busy_res,
                     got.walk_done);
        end else begin
          want = expected_coils.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result %0d expected in1=%b in2=%b en=%b busy=%b done=%b,",
                        " got in1=%b in2=%b en=%b busy=%b done=%b"}, $time, results_checked,
                       want.coil_in1, want.coil_in2, want.motor_enable, want.busy_res,
                       want.walk_done, got.coil_in1, got.coil_in2, got.motor_enable,
                       got.busy_res, got.walk_done);
          end
        end
        results_checked++;
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        expected_coils.push_back(sequence_motor(command, step_count));
        cmds_accepted++;
      end
    end
  end

  // driver: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0 && !back_to_back) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        command <= next_cmd.cmd;
        step_count <= next_cmd.cnt;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(10, 25);
            default:    gap_left = $urandom_range(1, 6);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes at random spans; long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (holds_given < holds_wanted) begin
        holds_given++;
        hold_left = 120;
      end
      if (stall_span == 0) begin
        stall_span = $urandom_range(20, 80);
        stall_mode = $urandom_range(0, 3);
      end else begin
        stall_span--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 3) == 0);
          2:       res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic queue_cmd(input logic [CMD_BITS-1:0] cmd,
                           input logic [STEP_FIELD_BITS-1:0] cnt);
    motor_cmd_t c;
    c.cmd = cmd;
    c.cnt = cnt;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cmds_accepted != cmds_queued || expected_coils.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int         n;
    int         ticks;
    int         pick;
    int         ext;
    int         dly;
    logic       dir;
    logic [1:0] spd;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle block under reset settings: coils still low, nothing starts
    queue_cmd(CMD_TICK, 16'hffff);
    queue_cmd(CMD_WALK, 16'd0);
    queue_cmd(CMD_CLEAR, 16'd0);
    queue_cmd(CMD_OFF, 16'h5a5a);
    wait_idle();

    write_reg(REG_DIRECTION, 10'd1);
    write_reg(REG_SPEED, 10'd1);
    write_reg(REG_EXTENSION, 10'd0);
    // single step walk, zero extension expires on the very next tick
    queue_cmd(CMD_WALK, 16'd1);
    repeat (6) queue_cmd(CMD_TICK, 16'd0);
    // restart a running walk, then drop enable while it keeps stepping
    queue_cmd(CMD_WALK, 16'hffff);
    queue_cmd(CMD_TICK, 16'd0);
    queue_cmd(CMD_WALK, 16'd2);
    queue_cmd(CMD_OFF, 16'd0);
    repeat (7) queue_cmd(CMD_TICK, 16'd0);
    wait_idle();

    for (int phase = 0; cmds_queued < 620; phase++) begin
      case (phase)
        0: begin
          dir = 1'b0;
          spd = 2'd3;
          ext = 1000;
        end
        1: begin
          dir = 1'b1;
          spd = 2'd2;
          ext = 0;
        end
        default: begin
          dir = 1'($urandom_range(0, 1));
          spd = 2'($urandom_range(0, 3));
          pick = $urandom_range(0, 9);
          ext = (pick < 7) ? $urandom_range(0, 12) : (pick < 9) ? $urandom_range(13, 40) : 0;
        end
      endcase
      write_reg(REG_DIRECTION, CFG_DATA_BITS'(dir));
      write_reg(REG_SPEED, CFG_DATA_BITS'(spd));
      write_reg(REG_EXTENSION, CFG_DATA_BITS'(ext));
      dly = int'(DELAY_MS[10*spd +: 10]);
      if (phase == 1) begin
        // sender keeps offering while the receiver holds off
        back_to_back = 1'b1;
        holds_wanted++;
      end

      repeat ($urandom_range(3, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          queue_cmd(CMD_WALK, STEP_FIELD_BITS'(n));
          ticks = walk_ticks(n, dly, ext) + $urandom_range(0, 2);
          if (ext > 100 && ticks > 60) ticks = 60;
          repeat (ticks) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) queue_cmd(CMD_OFF, STEP_FIELD_BITS'($urandom));
            else if (pick < 5) queue_cmd(CMD_CLEAR, STEP_FIELD_BITS'($urandom));
            queue_cmd(CMD_TICK, STEP_FIELD_BITS'($urandom));
          end
        end else if (pick < 88) begin
          // long walk cut short by a clear
          queue_cmd(CMD_WALK, STEP_FIELD_BITS'($urandom));
          repeat ($urandom_range(0, 20)) queue_cmd(CMD_TICK, STEP_FIELD_BITS'($urandom));
          queue_cmd(CMD_CLEAR, STEP_FIELD_BITS'($urandom));
          ticks = ((dly > ext) ? dly : ext) + ((ext < 1) ? 1 : ext) + 2;
          if (ext > 100 && ticks > 60) ticks = 60;
          repeat (ticks) queue_cmd(CMD_TICK, STEP_FIELD_BITS'($urandom));
        end else begin
          repeat ($urandom_range(1, 6))
            queue_cmd(CMD_BITS'($urandom_range(0, 3)), STEP_FIELD_BITS'($urandom));
        end
      end
      wait_idle();
      back_to_back = 1'b0;
    end

    if (mismatches == 0 && expected_coils.size() == 0) begin
      $display("stepper_phase_sequencer_core: match");
    end else begin
      $display("stepper_phase_sequencer_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("stepper_phase_sequencer_core: mismatch");
    $finish;
  end

endmodule

// File: stepper_phase_sequencer_core.f
hdl/spseq_pkg.sv
hdl/spseq_core.sv
hdl/spseq_out.sv
hdl/stepper_phase_sequencer_core.sv
verif/tb_stepper_phase_sequencer_core.sv
